// ===== rtl/dfs_maze_carver_macros.svh =====
// ----------------------------------------------------------------------------
// dfs_maze_carver_macros.svh
// assertion macros shared by the maze carver rtl
// ----------------------------------------------------------------------------
`ifndef DFS_MAZE_CARVER_MACROS_SVH
`define DFS_MAZE_CARVER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define DMC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dfs_maze_carver assertion failed");

// when a holds, b must hold in the same cycle
`define DMC_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("dfs_maze_carver implication failed");

// when a holds, b must hold in the next cycle
`define DMC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("dfs_maze_carver next-cycle check failed");

`else

`define DMC_ASSERT(lbl, clk, rst_n, prop)
`define DMC_ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define DMC_ASSERT_NEXT(lbl, clk, rst_n, a, b)

`endif

`endif

// ===== rtl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// shared constants for the depth-first maze carver
// ----------------------------------------------------------------------------
package dmc_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// width of the generation tag kept per visited-map entry
	localparam int EPOCH_W = 4;

	// configuration port
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAZE_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAZE_COLS = 1'd1;
	localparam logic [CFG_W-1:0] MAZE_ROWS_RESET = 7'd64;
	localparam logic [CFG_W-1:0] MAZE_COLS_RESET = 7'd64;

	// input commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_CARVE = 1'b1;

	// wall directions, also the neighbour scan order
	localparam int DIR_N = 4;
	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	localparam int COORD_W = 6;

endpackage

// ===== rtl/dfs_maze_carver.sv =====
// ----------------------------------------------------------------------------
// dfs_maze_carver
// randomized depth-first maze carver with an explicit cell stack in memory
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one beat per command: start a new
//   maze, or carve the next wall with random_pick choosing the neighbour.
//   output channel (out_valid/out_ready) returns exactly one beat per input
//   beat: the removed wall (cell_row, cell_col, wall_direction), finished, or
//   all zeros for a start.
//   maze_rows and maze_cols are written through cfg_we/cfg_index/cfg_data; the
//   user must do so only while the block is idle (the block does not enforce it).
// sequence:
//   a carve with no backtracking reads the stack top, makes four visited-map
//   reads plus a capture step, then picks a neighbour and writes the result.
//   each popped cell adds another stack read and scan. a start or a carve on an
//   empty stack loads its result from a single state. no new beat is taken
//   until the result is loaded and the block is back in idle.
//   the visited map carries a generation tag per cell; after reset, on the
//   16th start and on every 15th start after that, a clearing pass over all
//   2**(row bits + col bits) entries (4096 with default sizes) runs with
//   in_ready low.
// stall:
//   the result sits in an output register; the block finishes its current
//   item and holds there until the register frees, then returns to idle.
// ----------------------------------------------------------------------------
`include "dfs_maze_carver_macros.svh"

module dfs_maze_carver #(
	parameter int MAX_ROWS = dmc_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = dmc_pkg::DEF_MAX_COLS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dmc_pkg::CFG_W-1:0]      cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [7:0]                     random_pick,
	// output channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dmc_pkg::COORD_W-1:0]    cell_row,
	output logic [dmc_pkg::COORD_W-1:0]    cell_col,
	output logic [1:0]                     wall_direction,
	output logic                           finished
);
	import dmc_pkg::*;

	localparam int RW         = $clog2(MAX_ROWS);
	localparam int CW         = $clog2(MAX_COLS);
	localparam int VAW        = RW + CW;
	localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
	localparam int SAW        = $clog2(CELL_COUNT);
	localparam int HW         = $clog2(CELL_COUNT + 1);
	localparam int DW         = 9;
	localparam logic [DW-1:0] MAX_ROWS_D = DW'(MAX_ROWS);
	localparam logic [DW-1:0] MAX_COLS_D = DW'(MAX_COLS);
	localparam logic [HW-1:0] CELL_COUNT_H = HW'(CELL_COUNT);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_TOP,
		ST_SCAN,
		ST_PICK,
		ST_FIN
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     maze_rows_q;
	logic [CFG_W-1:0]     maze_cols_q;
	logic [HW-1:0]        height_q;
	logic [EPOCH_W-1:0]   epoch_q;
	logic [VAW-1:0]       clr_q;
	logic                 start_pend_q;
	logic [2:0]           scan_q;
	logic [DIR_N-1:0]     avail_q;
	logic [7:0]           pick_q;
	logic [RW-1:0]        row_q;
	logic [CW-1:0]        col_q;
	logic                 out_valid_q;
	logic [COORD_W-1:0]   cell_row_q;
	logic [COORD_W-1:0]   cell_col_q;
	logic [1:0]           wall_dir_q;
	logic                 finished_q;

	// memories
	logic [EPOCH_W-1:0]   visited_mem [2**VAW];
	logic [VAW-1:0]       stack_mem [CELL_COUNT];
	logic [EPOCH_W-1:0]   vis_rdata_q;
	logic [VAW-1:0]       stack_rdata_q;

	logic                 vis_we;
	logic [VAW-1:0]       vis_waddr;
	logic [EPOCH_W-1:0]   vis_wdata;
	logic [VAW-1:0]       vis_raddr;
	logic                 stack_we;
	logic [SAW-1:0]       stack_waddr;
	logic [VAW-1:0]       stack_wdata;
	logic [SAW-1:0]       stack_raddr;

	logic [DW-1:0]        rows_eff;
	logic [DW-1:0]        cols_eff;
	logic [DIR_N-1:0]     nb_inb;
	logic [VAW-1:0]       nb_addr [DIR_N];
	logic [HW-1:0]        top_idx;
	logic [HW-1:0]        pop_idx;
	logic [2:0]           avail_cnt;
	logic [10:0]          pick_prod;
	logic [1:0]           sel_dir;
	logic                 out_free;
	logic                 in_fire;
	logic [1:0]           scan_dir;
	logic [1:0]           cap_dir;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// effective grid size: zero acts as one, clamp to the build maximum
	always_comb begin
		if (maze_rows_q == '0) begin
			rows_eff = DW'(1);
		end else if (DW'(maze_rows_q) > MAX_ROWS_D) begin
			rows_eff = MAX_ROWS_D;
		end else begin
			rows_eff = DW'(maze_rows_q);
		end
		if (maze_cols_q == '0) begin
			cols_eff = DW'(1);
		end else if (DW'(maze_cols_q) > MAX_COLS_D) begin
			cols_eff = MAX_COLS_D;
		end else begin
			cols_eff = DW'(maze_cols_q);
		end
	end

	// neighbour addresses and grid bounds for the latched top cell
	always_comb begin
		logic [RW:0] r_dn;
		logic [CW:0] c_rt;
		r_dn = {1'b0, row_q} + (RW+1)'(1);
		c_rt = {1'b0, col_q} + (CW+1)'(1);
		nb_inb[DIR_DOWN]  = (DW'(r_dn) < rows_eff) && (DW'(col_q) < cols_eff);
		nb_inb[DIR_UP]    = (row_q != '0) && (DW'(row_q) - DW'(1) < rows_eff)
			&& (DW'(col_q) < cols_eff);
		nb_inb[DIR_RIGHT] = (DW'(row_q) < rows_eff) && (DW'(c_rt) < cols_eff);
		nb_inb[DIR_LEFT]  = (col_q != '0) && (DW'(row_q) < rows_eff)
			&& (DW'(col_q) - DW'(1) < cols_eff);
		nb_addr[DIR_DOWN]  = {r_dn[RW-1:0], col_q};
		nb_addr[DIR_UP]    = {row_q - RW'(1), col_q};
		nb_addr[DIR_RIGHT] = {row_q, c_rt[CW-1:0]};
		nb_addr[DIR_LEFT]  = {row_q, col_q - CW'(1)};
	end

	// choose neighbour number (pick * count) >> 8 among the open ones
	always_comb begin
		logic [2:0] seen;
		logic [2:0] want;
		avail_cnt = 3'(avail_q[0]) + 3'(avail_q[1]) + 3'(avail_q[2]) + 3'(avail_q[3]);
		pick_prod = 11'(pick_q) * 11'(avail_cnt);
		want      = pick_prod[10:8];
		seen      = '0;
		sel_dir   = DIR_DOWN;
		for (int d = 0; d < DIR_N; d++) begin
			if (avail_q[d]) begin
				if (seen == want) begin
					sel_dir = 2'(d);
				end
				seen = seen + 3'd1;
			end
		end
	end

	assign top_idx  = height_q - HW'(1);
	assign pop_idx  = height_q - HW'(2);
	assign scan_dir = scan_q[1:0];
	assign cap_dir  = 2'(scan_q - 3'd1);

	// memory port control
	always_comb begin
		vis_we      = 1'b0;
		vis_waddr   = '0;
		vis_wdata   = '0;
		stack_we    = 1'b0;
		stack_waddr = '0;
		stack_wdata = '0;
		vis_raddr   = nb_addr[scan_dir];
		stack_raddr = (state_q == ST_PICK) ? pop_idx[SAW-1:0] : top_idx[SAW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
			end
			ST_START: begin
				if (out_free) begin
					vis_we    = 1'b1;
					vis_wdata = epoch_q + EPOCH_W'(1);
					stack_we  = 1'b1;
				end
			end
			ST_PICK: begin
				if (out_free && avail_cnt != '0) begin
					vis_we      = 1'b1;
					vis_waddr   = nb_addr[sel_dir];
					vis_wdata   = epoch_q;
					stack_we    = (height_q < CELL_COUNT_H);
					stack_waddr = height_q[SAW-1:0];
					stack_wdata = nb_addr[sel_dir];
				end
			end
			default: begin
			end
		endcase
	end

	// every write lands before any later read of the same entry, so neither
	// memory needs forwarding
	always_ff @(posedge clk) begin
		if (vis_we) begin
			visited_mem[vis_waddr] <= vis_wdata;
		end
		vis_rdata_q <= visited_mem[vis_raddr];
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
		stack_rdata_q <= stack_mem[stack_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maze_rows_q <= MAZE_ROWS_RESET;
			maze_cols_q <= MAZE_COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAZE_ROWS: maze_rows_q <= cfg_data;
				REG_MAZE_COLS: maze_cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			height_q     <= '0;
			epoch_q      <= '0;
			clr_q        <= '0;
			start_pend_q <= 1'b0;
			scan_q       <= '0;
			avail_q      <= '0;
			pick_q       <= '0;
			row_q        <= '0;
			col_q        <= '0;
			out_valid_q  <= 1'b0;
			cell_row_q   <= '0;
			cell_col_q   <= '0;
			wall_dir_q   <= DIR_DOWN;
			finished_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + VAW'(1);
					if (clr_q == '1) begin
						epoch_q      <= '0;
						start_pend_q <= 1'b0;
						state_q      <= start_pend_q ? ST_START : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						pick_q <= random_pick;
						if (command == CMD_START) begin
							if (epoch_q == '1) begin
								// tags exhausted: wipe the map first
								start_pend_q <= 1'b1;
								clr_q        <= '0;
								state_q      <= ST_CLEAR;
							end else begin
								state_q <= ST_START;
							end
						end else if (height_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_TOP;
						end
					end
				end
				ST_START: begin
					if (out_free) begin
						epoch_q     <= epoch_q + EPOCH_W'(1);
						height_q    <= HW'(1);
						out_valid_q <= 1'b1;
						cell_row_q  <= '0;
						cell_col_q  <= '0;
						wall_dir_q  <= DIR_DOWN;
						finished_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_TOP: begin
					row_q   <= stack_rdata_q[VAW-1:CW];
					col_q   <= stack_rdata_q[CW-1:0];
					scan_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// read for neighbour n goes out at scan n, data lands at scan n+1
					if (scan_q != '0) begin
						avail_q[cap_dir] <= nb_inb[cap_dir] && (vis_rdata_q != epoch_q);
					end
					scan_q <= scan_q + 3'd1;
					if (scan_q == 3'(DIR_N)) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (avail_cnt == '0) begin
						// dead end: pop and rescan the new top, or finish if the stack empties
						height_q <= top_idx;
						state_q  <= (height_q == HW'(1)) ? ST_FIN : ST_TOP;
					end else if (out_free) begin
						if (height_q < CELL_COUNT_H) begin
							height_q <= height_q + HW'(1);
						end
						out_valid_q <= 1'b1;
						cell_row_q  <= COORD_W'(row_q);
						cell_col_q  <= COORD_W'(col_q);
						wall_dir_q  <= sel_dir;
						finished_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cell_row_q  <= '0;
						cell_col_q  <= '0;
						wall_dir_q  <= DIR_DOWN;
						finished_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign cell_row       = cell_row_q;
	assign cell_col       = cell_col_q;
	assign wall_direction = wall_dir_q;
	assign finished       = finished_q;

	`DMC_ASSERT(a_height_bound, clk, arst_n, height_q <= CELL_COUNT_H)
	`DMC_ASSERT_NEXT(a_start_path, clk, arst_n, in_fire && command == CMD_START,
		state_q == ST_START || state_q == ST_CLEAR)
	`DMC_ASSERT_IMPL(a_finished_clean, clk, arst_n, out_valid_q && finished_q,
		cell_row_q == '0 && cell_col_q == '0 && wall_dir_q == DIR_DOWN)
	`DMC_ASSERT_IMPL(a_live_epoch, clk, arst_n, state_q == ST_IDLE && height_q != '0,
		epoch_q != '0)

endmodule
